FILE: rtl/core/pnn_pkg.sv
// Shared types, constants and arithmetic helpers for the Newell normal block.
`default_nettype none
package pnn_pkg;

    localparam int COORD_BITS = 24;
    localparam int SUM_W      = 60;
    localparam int PROD_W     = 2 * (COORD_BITS + 1);
    localparam int NRM_W      = 30;   // magnitude width after normalizing shift
    localparam int Q_W        = 17;   // unit normal magnitude, up to 2^16
    localparam int DIV_W      = 48;   // dividend width of the normalize divide
    localparam int ROOT_W     = 32;

    localparam logic signed [SUM_W-1:0] ACC_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ACC_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_ADD, S_CMUL, S_CADD, S_CHECK, S_NINIT,
        S_SHIFT, S_SQ, S_SQRT, S_DINIT, S_DIV, S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_ADD, OP_CMUL, OP_NINIT, OP_NSHIFT,
        OP_SQ, OP_SQRT, OP_DINIT, OP_DIV, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic zero;
        logic mode;
        logic shift_done;
        logic sq_done;
        logic sqrt_done;
        logic div_done;
        logic out_busy;
    } t_stat;

    // One Newell cross term: (a0 - a1) * (b0 + b1)
    function automatic logic signed [PROD_W-1:0] cross_term(
        input logic signed [COORD_BITS-1:0] a0,
        input logic signed [COORD_BITS-1:0] a1,
        input logic signed [COORD_BITS-1:0] b0,
        input logic signed [COORD_BITS-1:0] b1
    );
        logic signed [COORD_BITS:0] d;
        logic signed [COORD_BITS:0] s;
        d = {a0[COORD_BITS-1], a0} - {a1[COORD_BITS-1], a1};
        s = {b0[COORD_BITS-1], b0} + {b1[COORD_BITS-1], b1};
        return d * s;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/polygon_newell_normal.sv
// Polygon normal by Newell's method: twice the area vector or unit normal per polygon.
// Each vertex is accepted and then accumulated; after the last vertex the block
// closes the polygon with the first vertex, checks the sum and emits (mode 0).
// Mode 1, for a nonzero sum, adds the normalize shift, the sum of squares,
// 32 square-root steps and 3 x 48 divide steps in one shared serial divider.
// Reset (synchronous, active low) clears the polygon state, mode and output valid.
`default_nettype none
module polygon_newell_normal import pnn_pkg::*; #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_WIDTH  = 24
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [71:0]  i_s_tdata,   // pos_x, pos_y, pos_z
    input  wire          i_s_tlast,   // last_vertex
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [183:0] o_m_tdata,   // out_x, out_y, out_z, zero pad
    output logic [1:0]   o_m_tuser,   // zero_length, overflowed
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire          i_cfg_data   // mode
);

    t_cmd               cmd;
    t_stat              stat;
    logic [3*SUM_W-1:0] out_vec;
    logic               zero_length;
    logic               overflowed;

    pnn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pnn_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_pos_x       (i_s_tdata[23:0]),
        .i_pos_y       (i_s_tdata[47:24]),
        .i_pos_z       (i_s_tdata[71:48]),
        .i_last        (i_s_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_out_vec     (out_vec),
        .o_zero_length (zero_length),
        .o_overflowed  (overflowed)
    );

    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = {4'b0, out_vec};
    assign o_m_tuser   = {overflowed, zero_length};

endmodule
`default_nettype wire

FILE: rtl/core/pnn_ctrl.sv
// Sequencer for vertex accumulation, polygon closing and normalization.
`default_nettype none
module pnn_ctrl import pnn_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.op = OP_ADD;
                n_state  = i_stat.last ? S_CMUL : S_IDLE;
            end
            S_CMUL: begin
                o_cmd.op = OP_CMUL;
                n_state  = S_CADD;
            end
            S_CADD: begin
                o_cmd.op = OP_ADD;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                n_state = (i_stat.mode && !i_stat.zero) ? S_NINIT : S_EMIT;
            end
            S_NINIT: begin
                o_cmd.op = OP_NINIT;
                n_state  = S_SHIFT;
            end
            S_SHIFT: begin
                if (i_stat.shift_done) begin
                    n_state = S_SQ;
                end else begin
                    o_cmd.op = OP_NSHIFT;
                end
            end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                if (i_stat.sq_done) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (i_stat.sqrt_done) begin
                    n_state = S_DINIT;
                end else begin
                    o_cmd.op = OP_SQRT;
                end
            end
            S_DINIT: begin
                o_cmd.op = OP_DINIT;
                n_state  = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.op = OP_DIV;
                end
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/core/pnn_datapath.sv
// Accumulators, normalize shifter, square root and divider, result register.
`default_nettype none
module pnn_datapath import pnn_pkg::*; #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_WIDTH  = 24
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  t_cmd                         i_cmd,
    output t_stat                        o_stat,
    input  wire signed [COORD_BITS-1:0]  i_pos_x,
    input  wire signed [COORD_BITS-1:0]  i_pos_y,
    input  wire signed [COORD_BITS-1:0]  i_pos_z,
    input  wire                          i_last,
    input  wire                          i_cfg_valid,
    input  wire                          i_cfg_data,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [3*SUM_W-1:0]           o_out_vec,
    output logic                         o_zero_length,
    output logic                         o_overflowed
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 2);
    localparam int SH    = COORD_BITS - COORD_WIDTH;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

    logic signed [COORD_BITS-1:0] r_first [3];
    logic signed [COORD_BITS-1:0] r_prev  [3];
    logic signed [SUM_W-1:0]      r_sum   [3];
    logic signed [PROD_W-1:0]     r_prod  [3];
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_sat;
    logic                         r_last;
    logic                         r_mode;

    logic [SUM_W-1:0]       r_a [3];
    logic [SUM_W-1:0]       r_m;
    logic [1:0]             r_k;
    logic [2*NRM_W-1:0]     r_sqp;
    logic [2*NRM_W+1:0]     r_l2;
    logic [63:0]            r_v;
    logic [63:0]            r_root;
    logic [63:0]            r_bit;
    logic [ROOT_W-1:0]      r_len;
    logic [DIV_W-1:0]       r_num;
    logic [ROOT_W-1:0]      r_rem;
    logic [Q_W-1:0]         r_q;
    logic [5:0]             r_dcnt;
    logic [1:0]             r_idx;
    logic signed [SUM_W-1:0] r_nrm [3];

    logic                   r_ovalid;
    logic [3*SUM_W-1:0]     r_ovec;
    logic                   r_ozero;
    logic                   r_oovf;

    logic signed [COORD_BITS-1:0] cur [3];
    logic signed [COORD_BITS-1:0] p0  [3];
    logic signed [COORD_BITS-1:0] p1  [3];
    logic signed [PROD_W-1:0]     pr  [3];
    logic signed [SUM_W:0]        acc [3];
    logic                         add_clamp;
    logic                         zero;
    logic [NRM_W-1:0]             a_sq;
    logic [NRM_W-1:0]             a_div;
    logic [NRM_W-1:0]             a_nxt;
    logic [63:0]                  sq_try;
    logic [ROOT_W:0]              rem_x;
    logic                         q_bit;
    logic [ROOT_W-1:0]            len_v;
    logic [Q_W-1:0]               q_fin;
    logic signed [SUM_W-1:0]      q_ext;
    logic                         neg;

    assign cur[0] = $signed(i_pos_x <<< SH) >>> SH;
    assign cur[1] = $signed(i_pos_y <<< SH) >>> SH;
    assign cur[2] = $signed(i_pos_z <<< SH) >>> SH;

    // pair operands: (prev, cur) on load, (prev, first) when closing
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p0[i] = r_prev[i];
            p1[i] = (i_cmd.op == OP_CMUL) ? r_first[i] : cur[i];
        end
        pr[0] = cross_term(p0[1], p1[1], p0[2], p1[2]);
        pr[1] = cross_term(p0[2], p1[2], p0[0], p1[0]);
        pr[2] = cross_term(p0[0], p1[0], p0[1], p1[1]);
        add_clamp = 1'b0;
        for (int i = 0; i < 3; i++) begin
            acc[i] = {r_sum[i][SUM_W-1], r_sum[i]} + (SUM_W+1)'(r_prod[i]);
            if ((acc[i] > (SUM_W+1)'(ACC_MAX)) || (acc[i] < (SUM_W+1)'(ACC_MIN))) begin
                add_clamp = 1'b1;
            end
        end
    end

    assign zero = (r_sum[0] == '0) && (r_sum[1] == '0) && (r_sum[2] == '0);

    always_comb begin
        case (r_k)
            2'd0:    a_sq = r_a[0][NRM_W-1:0];
            2'd1:    a_sq = r_a[1][NRM_W-1:0];
            default: a_sq = r_a[2][NRM_W-1:0];
        endcase
        case (r_idx)
            2'd0:    a_div = r_a[0][NRM_W-1:0];
            2'd1:    a_div = r_a[1][NRM_W-1:0];
            default: a_div = r_a[2][NRM_W-1:0];
        endcase
        case (r_idx)
            2'd0:    a_nxt = r_a[1][NRM_W-1:0];
            default: a_nxt = r_a[2][NRM_W-1:0];
        endcase
        case (r_idx)
            2'd0:    neg = r_sum[0][SUM_W-1];
            2'd1:    neg = r_sum[1][SUM_W-1];
            default: neg = r_sum[2][SUM_W-1];
        endcase
        sq_try = r_root + r_bit;
        rem_x  = {r_rem, r_num[DIV_W-1]};
        q_bit  = (rem_x >= {1'b0, r_len});
        q_fin  = {r_q[Q_W-2:0], q_bit};
        q_ext  = SUM_W'(q_fin);
        len_v  = (r_root == '0) ? ROOT_W'(1) : r_root[ROOT_W-1:0];
    end

    // accumulation state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_sat  <= 1'b0;
            r_mode <= 1'b0;
            r_last <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_first[i] <= '0;
                r_prev[i]  <= '0;
                r_sum[i]   <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_last <= i_last;
                    for (int i = 0; i < 3; i++) begin
                        r_prev[i] <= cur[i];
                        if (r_cnt == '0) begin
                            r_first[i] <= cur[i];
                        end
                    end
                    if (r_cnt >= CNT_MAX) begin
                        r_sat <= 1'b1;
                    end
                    if (r_cnt <= CNT_MAX) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                OP_ADD: begin
                    for (int i = 0; i < 3; i++) begin
                        if (acc[i] > (SUM_W+1)'(ACC_MAX)) begin
                            r_sum[i] <= ACC_MAX;
                        end else if (acc[i] < (SUM_W+1)'(ACC_MIN)) begin
                            r_sum[i] <= ACC_MIN;
                        end else begin
                            r_sum[i] <= acc[i][SUM_W-1:0];
                        end
                    end
                    if (add_clamp) begin
                        r_sat <= 1'b1;
                    end
                end
                OP_EMIT: begin
                    r_cnt  <= '0;
                    r_sat  <= 1'b0;
                    r_last <= 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        r_first[i] <= '0;
                        r_prev[i]  <= '0;
                        r_sum[i]   <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // product stage, normalize datapath
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    r_prod[i] <= (r_cnt == '0) ? '0 : pr[i];
                end
            end
            OP_CMUL: begin
                for (int i = 0; i < 3; i++) begin
                    r_prod[i] <= pr[i];
                end
            end
            OP_NINIT: begin
                for (int i = 0; i < 3; i++) begin
                    r_a[i] <= r_sum[i][SUM_W-1] ? SUM_W'(-r_sum[i]) : r_sum[i];
                end
                r_k  <= '0;
                r_l2 <= '0;
                // largest of the three magnitudes
                begin
                    logic [SUM_W-1:0] mx;
                    logic [SUM_W-1:0] ab [3];
                    for (int i = 0; i < 3; i++) begin
                        ab[i] = r_sum[i][SUM_W-1] ? SUM_W'(-r_sum[i]) : r_sum[i];
                    end
                    mx = ab[0];
                    if (ab[1] > mx) mx = ab[1];
                    if (ab[2] > mx) mx = ab[2];
                    r_m <= mx;
                end
            end
            OP_NSHIFT: begin
                if (r_m >= SUM_W'(64'd1 << NRM_W)) begin
                    r_m <= r_m >> 1;
                    for (int i = 0; i < 3; i++) r_a[i] <= r_a[i] >> 1;
                end else begin
                    r_m <= r_m << 1;
                    for (int i = 0; i < 3; i++) r_a[i] <= r_a[i] << 1;
                end
            end
            OP_SQ: begin
                if (r_k != 2'd3) begin
                    r_sqp <= a_sq * a_sq;
                    r_k   <= r_k + 2'd1;
                end
                if (r_k != 2'd0) begin
                    r_l2 <= r_l2 + (2*NRM_W+2)'(r_sqp);
                end
                if (r_k == 2'd3) begin
                    r_v    <= 64'(r_l2) + 64'(r_sqp);
                    r_root <= '0;
                    r_bit  <= 64'd1 << 62;
                end
            end
            OP_SQRT: begin
                if (r_v >= sq_try) begin
                    r_v    <= r_v - sq_try;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_DINIT: begin
                r_len  <= len_v;
                r_idx  <= '0;
                r_num  <= {2'b0, r_a[0][NRM_W-1:0], 16'b0} + DIV_W'(len_v >> 1);
                r_rem  <= '0;
                r_q    <= '0;
                r_dcnt <= '0;
            end
            OP_DIV: begin
                if (r_dcnt == 6'(DIV_W - 1)) begin
                    case (r_idx)
                        2'd0:    r_nrm[0] <= neg ? -q_ext : q_ext;
                        2'd1:    r_nrm[1] <= neg ? -q_ext : q_ext;
                        default: r_nrm[2] <= neg ? -q_ext : q_ext;
                    endcase
                    r_idx  <= r_idx + 2'd1;
                    r_num  <= {2'b0, a_nxt, 16'b0} + DIV_W'(r_len >> 1);
                    r_rem  <= '0;
                    r_q    <= '0;
                    r_dcnt <= '0;
                end else begin
                    if (q_bit) begin
                        r_rem <= ROOT_W'(rem_x - {1'b0, r_len});
                    end else begin
                        r_rem <= rem_x[ROOT_W-1:0];
                    end
                    r_q    <= q_fin;
                    r_num  <= r_num << 1;
                    r_dcnt <= r_dcnt + 6'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            r_ozero <= zero;
            r_oovf  <= r_sat;
            if (!r_mode) begin
                r_ovec <= {r_sum[2], r_sum[1], r_sum[0]};
            end else if (zero) begin
                r_ovec <= '0;
            end else begin
                r_ovec <= {r_nrm[2], r_nrm[1], r_nrm[0]};
            end
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_out_vec     = r_ovec;
    assign o_zero_length = r_ozero;
    assign o_overflowed  = r_oovf;

    assign o_stat.last       = r_last;
    assign o_stat.zero       = zero;
    assign o_stat.mode       = r_mode;
    assign o_stat.shift_done = (r_m < SUM_W'(64'd1 << NRM_W)) &&
                               (r_m >= SUM_W'(64'd1 << (NRM_W - 1)));
    assign o_stat.sq_done    = (r_k == 2'd3);
    assign o_stat.sqrt_done  = (r_bit == '0);
    assign o_stat.div_done   = (r_idx == 2'd3);
    assign o_stat.out_busy   = r_ovalid;

endmodule
`default_nettype wire

FILE: rtl/core/pnn_checker.sv
// Port-level checks for the Newell normal block, bound to the top level.
`default_nettype none
module pnn_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         o_m_tvalid,
    input wire         i_m_tready,
    input wire [183:0] o_m_tdata,
    input wire [1:0]   o_m_tuser
);

    // nothing valid right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // stalled request holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // zero vector gives all-zero data in either mode
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("zero_length with nonzero data");

    // results are spaced by the polygon pipeline
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready |=> !o_m_tvalid)
        else $error("back-to-back results");

endmodule

bind polygon_newell_normal pnn_checker u_pnn_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire
